// ===== hdl/go_back_n_sender_window_unit_assert.svh =====
// Assertion macros shared by the checker of the Go-Back-N sender window unit.
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbn: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbn: next-cycle check failed");

`endif

// ===== hdl/gbn_pkg.sv =====
// Types, codes and sizes shared by the Go-Back-N sender window unit.
package gbn_pkg;

  localparam int SEQ_SPACE  = 8;
  localparam int SEQ_W      = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_W  = 32;
  localparam int WIN_W      = 3;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_RESTART = 2'd2;
  localparam logic [1:0] TMR_STOP    = 2'd3;

  localparam logic [1:0] ACK_NONE     = 2'd0;
  localparam logic [1:0] ACK_CORRUPT  = 2'd1;
  localparam logic [1:0] ACK_OUTSIDE  = 2'd2;
  localparam logic [1:0] ACK_ACCEPTED = 2'd3;

  typedef struct packed {
    logic [1:0]           command;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     ack_number;
    logic                 ack_checksum_ok;
  } gbn_in_t;

  typedef struct packed {
    logic                 send_accepted;
    logic                 packet_valid;
    logic [SEQ_W-1:0]     packet_seq;
    logic [PAYLOAD_W-1:0] packet_payload;
    logic [1:0]           timer_action;
    logic [1:0]           ack_status;
    logic                 last;
  } gbn_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPLAY
  } gbn_state_t;

  typedef struct packed {
    logic accept;
    logic replay;
  } gbn_cmd_t;

  typedef struct packed {
    logic replay_needed;
    logic replay_last;
  } gbn_status_t;

endpackage

// ===== hdl/go_back_n_sender_window_unit.sv =====
// Top level of the Go-Back-N sender window unit: controller, datapath and ports.
//
//  Channel   Ports                        Handshake
//  --------  ---------------------------  -----------------------------------
//  input     start, busy, in_word         word taken when start high, busy low
//  result    out_valid, out_word          word shown for one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_data  written when valid and ready high
//
// A send, an acknowledgement, an unused command or a timeout with nothing
// outstanding yields its single result word in the cycle after the input
// word is taken, and busy stays low, so one word per cycle.
// A timeout with N packets outstanding raises busy for the replay and yields N
// words, each through the store's read register and the result register; the
// packet store has a single read port, read one entry per cycle.
// Reset is synchronous and active low; it empties the window and sets the
// window size to four. The receiver cannot stall, so nothing holds off results.
module go_back_n_sender_window_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  gbn_pkg::gbn_in_t           in_word,
  output logic                       out_valid,
  output gbn_pkg::gbn_out_t          out_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gbn_pkg::WIN_W-1:0]  cfg_data
);
  import gbn_pkg::*;

  gbn_cmd_t    cmd;
  gbn_status_t status;
  logic        cfg_we;

  // The window size is only written between replays, so the controller's
  // idle state doubles as the configuration channel's ready.
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  gbn_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  gbn_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== hdl/gbn_ctrl.sv =====
// Controller: decides between taking a new word and replaying outstanding packets.
module gbn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gbn_pkg::gbn_status_t status,
  output logic                busy,
  output gbn_pkg::gbn_cmd_t   cmd
);
  import gbn_pkg::*;

  gbn_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && status.replay_needed) begin
          state_nxt = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (status.replay_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    cmd.accept = 1'b0;
    cmd.replay = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
      end
      ST_REPLAY: begin
        busy       = 1'b1;
        cmd.replay = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/gbn_dpath.sv =====
// Datapath: window pointers, packet store, replay index and the result register.
module gbn_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbn_pkg::gbn_in_t              in_word,
  input  gbn_pkg::gbn_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [gbn_pkg::WIN_W-1:0]     cfg_data,
  output gbn_pkg::gbn_status_t          status,
  output logic                          out_valid,
  output gbn_pkg::gbn_out_t             out_word
);
  import gbn_pkg::*;

  logic [PAYLOAD_W-1:0] store [SEQ_SPACE];
  logic [PAYLOAD_W-1:0] rd_data_r;

  logic [SEQ_W-1:0] window_base_r, next_sequence_r, idx_r;
  logic [WIN_W-1:0] window_size_r;
  logic             out_valid_r, out_valid_nxt;
  gbn_out_t         out_word_r, out_word_nxt;

  logic [SEQ_W-1:0] outs, ack_off, ack_next, replay_seq, rd_addr;
  logic             send_ok, ack_ok, is_send, is_ack;

  // Modulo arithmetic on the sequence space comes from the wrap of SEQ_W bits.
  assign outs       = next_sequence_r - window_base_r;
  assign ack_off    = in_word.ack_number - window_base_r;
  assign ack_next   = in_word.ack_number + SEQ_W'(1);
  assign replay_seq = window_base_r + idx_r;
  assign rd_addr    = cmd.replay ? (replay_seq + SEQ_W'(1)) : window_base_r;
  assign send_ok    = SEQ_W'(outs) < SEQ_W'(window_size_r);
  assign ack_ok     = in_word.ack_checksum_ok && (ack_off < outs);
  assign is_send    = in_word.command == CMD_SEND;
  assign is_ack     = in_word.command == CMD_ACK;

  assign status.replay_needed = (in_word.command == CMD_TIMEOUT) && (outs != '0);
  assign status.replay_last   = idx_r == (outs - SEQ_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept && is_send && send_ok) begin
      store[next_sequence_r] <= in_word.payload;
    end
    rd_data_r <= store[rd_addr];
  end

  always_comb begin
    out_word_nxt      = '0;
    out_word_nxt.last = 1'b1;
    if (cmd.replay) begin
      out_word_nxt.packet_valid   = 1'b1;
      out_word_nxt.packet_seq     = replay_seq;
      out_word_nxt.packet_payload = rd_data_r;
      out_word_nxt.timer_action   = (idx_r == '0) ? TMR_RESTART : TMR_NONE;
      out_word_nxt.last           = status.replay_last;
    end else begin
      case (in_word.command)
        CMD_SEND: begin
          if (send_ok) begin
            out_word_nxt.send_accepted  = 1'b1;
            out_word_nxt.packet_valid   = 1'b1;
            out_word_nxt.packet_seq     = next_sequence_r;
            out_word_nxt.packet_payload = in_word.payload;
            out_word_nxt.timer_action   = (outs == '0) ? TMR_START : TMR_NONE;
          end
        end
        CMD_ACK: begin
          if (!in_word.ack_checksum_ok) begin
            out_word_nxt.ack_status = ACK_CORRUPT;
          end else if (!ack_ok) begin
            out_word_nxt.ack_status = ACK_OUTSIDE;
          end else begin
            out_word_nxt.ack_status   = ACK_ACCEPTED;
            out_word_nxt.timer_action = (ack_next == next_sequence_r) ? TMR_STOP
                                                                       : TMR_RESTART;
          end
        end
        CMD_TIMEOUT: begin
          out_word_nxt.timer_action = TMR_RESTART;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = (cmd.accept && !status.replay_needed) || cmd.replay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r   <= '0;
      next_sequence_r <= '0;
      window_size_r   <= WINDOW_RESET;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        window_size_r <= cfg_data;
      end
      if (cmd.accept && is_send && send_ok) begin
        next_sequence_r <= next_sequence_r + SEQ_W'(1);
      end
      if (cmd.accept && is_ack && ack_ok) begin
        window_base_r <= ack_next;
      end
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (cmd.replay) begin
        idx_r <= idx_r + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/gbn_checker.sv =====
// Port-level checker for the Go-Back-N sender window unit, bound to the top level.
module gbn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input gbn_pkg::gbn_in_t  in_word,
  input logic              out_valid,
  input gbn_pkg::gbn_out_t out_word
);
  import gbn_pkg::*;
`include "go_back_n_sender_window_unit_assert.svh"

  // Anything but a timeout answers with a single final word in the next cycle.
  `GBN_ASSERT_NEXT(a_single_reply, clk, rst_n,
                   start && !busy && (in_word.command != CMD_TIMEOUT),
                   out_valid && out_word.last)

  // A word without a packet carries zero packet fields.
  `GBN_ASSERT_NOW(a_empty_packet, clk, rst_n, out_valid && !out_word.packet_valid,
                  (out_word.packet_seq == '0) && (out_word.packet_payload == '0))

  // An accepted send always carries its packet and ends its reply.
  `GBN_ASSERT_NOW(a_send_packet, clk, rst_n, out_valid && out_word.send_accepted,
                  out_word.packet_valid && out_word.last)

  // While a replay still has words to come, new input words are held off.
  `GBN_ASSERT_NOW(a_replay_busy, clk, rst_n, out_valid && !out_word.last, busy)

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);
